[src/sac_pkg.sv]
// Shared types, constants and register codes of the set-associative cache tag directory.
package sac_pkg;

  localparam int ADDR_W     = 64;
  localparam int TAG_W      = 64;
  localparam int CNT_W      = 32;
  localparam int IDX_RAW_W  = 16;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;
  localparam int OUT_DATA_W = 232;

  localparam int SETS_DEF     = 1024;
  localparam int WAYS_DEF     = 8;
  localparam int AGE_BITS_DEF = 16;

  localparam logic [CFG_IDX_W-1:0] REG_POLICY = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_OFFSET = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_INDEX  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_WAYS   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SEED   = 3'd4;

  localparam logic POLICY_LRU  = 1'b0;
  localparam logic POLICY_RAND = 1'b1;
  localparam logic CMD_WRITE   = 1'b1;

  localparam logic [31:0] LFSR_TAPS  = 32'h8020_0003;
  localparam logic [31:0] LFSR_RESET = 32'd1;

  typedef struct packed {
    logic fire;
    logic is_write;
    logic hit;
  } stat_upd_t;

  typedef struct packed {
    logic [CNT_W-1:0] write_miss;
    logic [CNT_W-1:0] read_miss;
    logic [CNT_W-1:0] miss;
    logic [CNT_W-1:0] hits;
    logic [CNT_W-1:0] writes;
    logic [CNT_W-1:0] reads;
    logic [CNT_W-1:0] accesses;
  } stats_t;

endpackage

[src/sac_tag_mem.sv]
// Tag, valid and age store: one row per set, synchronous write and registered read.
module sac_tag_mem
  import sac_pkg::*;
#(
  parameter int DEPTH = SETS_DEF,
  parameter int ROW_W = WAYS_DEF * (1 + TAG_W + AGE_BITS_DEF),
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [ROW_W-1:0] rd_data,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [ROW_W-1:0] wr_data
);

  logic [ROW_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

[src/sac_set_map.sv]
// Address split into tag and set index, with the set index reduced modulo the built sets.
module sac_set_map
  import sac_pkg::*;
#(
  parameter int SETS = SETS_DEF,
  localparam int SET_W = (SETS > 1) ? $clog2(SETS) : 1
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [ADDR_W-1:0] addr,
  input  logic [3:0]        offset_bits,
  input  logic [3:0]        index_bits,
  output logic              done,
  output logic [SET_W-1:0]  set_idx,
  output logic [TAG_W-1:0]  tag
);

  localparam logic [32:0] RECIP  = 33'((64'd1 << 32) / SETS);
  localparam logic [16:0] SETS_V = 17'(SETS);

  logic [2:0]           vld;
  logic [ADDR_W-1:0]    shifted;
  logic [IDX_RAW_W-1:0] mask;
  logic [4:0]           shamt;
  logic [IDX_RAW_W-1:0] idx_raw;
  logic [IDX_RAW_W-1:0] idx_s1;
  logic [IDX_RAW_W-1:0] idx_s2;
  logic [48:0]          prod1;
  logic [32:0]          prod2;
  logic [IDX_RAW_W-1:0] rem0;
  logic [IDX_RAW_W-1:0] rem1;

  assign shifted = addr >> offset_bits;
  assign mask    = (IDX_RAW_W'(1) << index_bits) - IDX_RAW_W'(1);
  assign shamt   = {1'b0, offset_bits} + {1'b0, index_bits};

  always_comb begin
    rem0 = idx_s2 - prod2[IDX_RAW_W-1:0];
    if ({1'b0, rem0} >= SETS_V) begin
      rem1 = rem0 - SETS_V[IDX_RAW_W-1:0];
    end else begin
      rem1 = rem0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      idx_raw <= shifted[IDX_RAW_W-1:0] & mask;
      tag     <= addr >> shamt;
    end
    prod1   <= {33'd0, idx_raw} * {16'd0, RECIP};
    idx_s1  <= idx_raw;
    prod2   <= {17'd0, prod1[47:32]} * {16'd0, SETS_V};
    idx_s2  <= idx_s1;
    set_idx <= rem1[SET_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld  <= '0;
      done <= 1'b0;
    end else begin
      vld  <= {vld[1:0], start};
      done <= vld[2];
    end
  end

endmodule

[src/sac_rand.sv]
// Replacement LFSR and the remainder of its value by the ways in use, one byte a cycle.
module sac_rand
  import sac_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        seed_load,
  input  logic [31:0] seed,
  input  logic        step,
  input  logic [3:0]  ways,
  output logic        done,
  output logic [2:0]  rem
);

  logic [31:0] lfsr;
  logic [31:0] lfsr_adv;
  logic [31:0] work;
  logic [3:0]  r;
  logic [3:0]  r_next;
  logic [1:0]  cnt;
  logic        busy;

  assign lfsr_adv = lfsr[0] ? ((lfsr >> 1) ^ LFSR_TAPS) : (lfsr >> 1);
  assign rem      = r[2:0];

  always_comb begin
    r_next = r;
    for (int k = 0; k < 8; k++) begin
      r_next = {r_next[2:0], work[31-k]};
      if (r_next >= ways) begin
        r_next = r_next - ways;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      lfsr <= LFSR_RESET;
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (seed_load) begin
        lfsr <= (seed == '0) ? LFSR_RESET : seed;
      end
      if (step) begin
        lfsr <= lfsr_adv;
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 2'd1;
        if (cnt == 2'd3) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      work <= lfsr_adv;
      r    <= '0;
    end else if (busy) begin
      work <= work << 8;
      r    <= r_next;
    end
  end

endmodule

[src/sac_stats.sv]
// Saturating access, read, write, hit and miss counters.
module sac_stats
  import sac_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  stat_upd_t upd,
  output stats_t    stats
);

  function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
    sat_inc = (v == '1) ? v : v + CNT_W'(1);
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      stats <= '0;
    end else if (upd.fire) begin
      stats.accesses <= sat_inc(stats.accesses);
      if (upd.is_write) begin
        stats.writes <= sat_inc(stats.writes);
      end else begin
        stats.reads <= sat_inc(stats.reads);
      end
      if (upd.hit) begin
        stats.hits <= sat_inc(stats.hits);
      end else begin
        stats.miss <= sat_inc(stats.miss);
        if (upd.is_write) begin
          stats.write_miss <= sat_inc(stats.write_miss);
        end else begin
          stats.read_miss <= sat_inc(stats.read_miss);
        end
      end
    end
  end

endmodule

[src/set_assoc_cache_tag_lru_top.sv]
// Top level of the set-associative cache tag directory with LRU or random replacement.
//
//   Channel  Direction  Signals                        Contents
//   s        in         s_tvalid s_tready s_tdata/user access: tuser cmd, tdata addr
//   m        out        m_tvalid m_tready m_tdata      result and counters
//   cfg      in         cfg_we cfg_addr cfg_wdata      register writes, no read-back
//
// An access passes through accept with the tag split, set reduction (two multiplier stages
// and a correction), the registered tag store read, lookup and the write-back of the row.
// A random eviction from a full set also waits on the LFSR remainder, a byte a cycle.
// After reset a clearing pass writes every set row before the first beat.
// A result beat waits in its output register; the next access is taken meanwhile and
// holds at write-back only while the previous beat has not been taken.
module set_assoc_cache_tag_lru_top
  import sac_pkg::*;
#(
  parameter int SETS     = SETS_DEF,
  parameter int WAYS     = WAYS_DEF,
  parameter int AGE_BITS = AGE_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [ADDR_W-1:0]     s_tdata,   // addr
  input  logic                  s_tuser,   // cmd
  output logic                  m_tvalid,
  input  logic                  m_tready,
  // hit, way_used[3], filled_empty, access, read, write, hit, miss, read miss,
  // write miss counts (32 each), zero pad
  output logic [OUT_DATA_W-1:0] m_tdata,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_addr,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  localparam int SET_W = (SETS > 1) ? $clog2(SETS) : 1;
  localparam int WAY_W = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int ENT_W = 1 + TAG_W + AGE_BITS;
  localparam int ROW_W = WAYS * ENT_W;
  localparam logic [AGE_BITS-1:0] AGE_MAX = '1;

  localparam logic [2:0] ST_CLR  = 3'd0;
  localparam logic [2:0] ST_IDLE = 3'd1;
  localparam logic [2:0] ST_MAP  = 3'd2;
  localparam logic [2:0] ST_LOOK = 3'd3;
  localparam logic [2:0] ST_RND  = 3'd4;
  localparam logic [2:0] ST_WB   = 3'd5;

  logic [2:0]       state;
  logic [SET_W-1:0] clr_addr;
  logic             policy;
  logic [3:0]       offset_bits;
  logic [3:0]       index_bits;
  logic [3:0]       ways_cfg;
  logic [3:0]       ways_eff;

  logic             cmd;
  logic [SET_W-1:0] set_sel;
  logic             hit;
  logic             found_empty;
  logic             rnd;
  logic [WAY_W-1:0] way;
  logic             out_hit;
  logic [2:0]       out_way;
  logic             out_filled;

  logic             map_done;
  logic [SET_W-1:0] map_set;
  logic [TAG_W-1:0] map_tag;
  logic             rnd_done;
  logic [2:0]       rnd_rem;
  logic             rnd_step;
  stats_t           stats;
  stat_upd_t        upd;

  logic             rd_en;
  logic [ROW_W-1:0] rd_row;
  logic             wr_en;
  logic [SET_W-1:0] wr_addr;
  logic [ROW_W-1:0] wr_row;
  logic [ROW_W-1:0] new_row;

  logic [WAYS-1:0]     rd_valid;
  logic [TAG_W-1:0]    rd_tag [WAYS];
  logic [AGE_BITS-1:0] rd_age [WAYS];
  logic [WAYS-1:0]     in_use;

  logic             hit_c;
  logic [WAY_W-1:0] hit_way_c;
  logic             empty_c;
  logic [WAY_W-1:0] empty_way_c;
  logic [WAY_W-1:0] lru_way_c;
  logic [WAY_W-1:0] way_fin;
  logic             accept;
  logic             out_free;
  logic             wb_fire;

  assign s_tready = (state == ST_IDLE);
  assign accept   = s_tvalid && s_tready;
  assign out_free = !m_tvalid || m_tready;
  assign wb_fire  = (state == ST_WB) && out_free;
  assign rd_en    = (state == ST_MAP) && map_done;
  assign rnd_step = (state == ST_LOOK) && !hit_c && !empty_c && (policy == POLICY_RAND);
  assign way_fin  = rnd ? WAY_W'(rnd_rem) : way;

  always_comb begin
    if (ways_cfg == 4'd0) begin
      ways_eff = 4'd1;
    end else if (ways_cfg > 4'(WAYS)) begin
      ways_eff = 4'(WAYS);
    end else begin
      ways_eff = ways_cfg;
    end
  end

  always_comb begin
    for (int i = 0; i < WAYS; i++) begin
      rd_valid[i] = rd_row[i*ENT_W];
      rd_tag[i]   = rd_row[i*ENT_W+1 +: TAG_W];
      rd_age[i]   = rd_row[i*ENT_W+1+TAG_W +: AGE_BITS];
      in_use[i]   = (4'(i) < ways_eff);
    end
  end

  always_comb begin
    logic [AGE_BITS-1:0] best;
    hit_c       = 1'b0;
    hit_way_c   = '0;
    empty_c     = 1'b0;
    empty_way_c = '0;
    for (int i = WAYS - 1; i >= 0; i--) begin
      if (in_use[i] && rd_valid[i] && (rd_tag[i] == map_tag)) begin
        hit_c     = 1'b1;
        hit_way_c = WAY_W'(i);
      end
      if (in_use[i] && !rd_valid[i]) begin
        empty_c     = 1'b1;
        empty_way_c = WAY_W'(i);
      end
    end
    best      = rd_age[0];
    lru_way_c = '0;
    for (int i = 1; i < WAYS; i++) begin
      if (in_use[i] && (rd_age[i] > best)) begin
        best      = rd_age[i];
        lru_way_c = WAY_W'(i);
      end
    end
  end

  always_comb begin
    logic                sel;
    logic                fill;
    logic                nv;
    logic [TAG_W-1:0]    nt;
    logic [AGE_BITS-1:0] na;
    new_row = '0;
    for (int i = 0; i < WAYS; i++) begin
      sel  = (WAY_W'(i) == way_fin);
      fill = !hit && sel;
      nv   = rd_valid[i] | fill;
      nt   = fill ? map_tag : rd_tag[i];
      na   = rd_age[i];
      if (hit || (policy == POLICY_LRU)) begin
        if (in_use[i] && (rd_age[i] != AGE_MAX)) begin
          na = rd_age[i] + AGE_BITS'(1);
        end
        if (sel) begin
          na = '0;
        end
      end
      new_row[i*ENT_W +: ENT_W] = {na, nt, nv};
    end
  end

  always_comb begin
    if (state == ST_CLR) begin
      wr_en   = 1'b1;
      wr_addr = clr_addr;
      wr_row  = '0;
    end else begin
      wr_en   = wb_fire;
      wr_addr = set_sel;
      wr_row  = new_row;
    end
  end

  assign upd.fire     = wb_fire;
  assign upd.is_write = (cmd == CMD_WRITE);
  assign upd.hit      = hit;

  assign m_tdata = {3'b000, stats.write_miss, stats.read_miss, stats.miss, stats.hits,
                    stats.writes, stats.reads, stats.accesses,
                    out_filled, out_way, out_hit};

  always_ff @(posedge clk) begin
    if (rst) begin
      policy      <= POLICY_LRU;
      offset_bits <= 4'd6;
      index_bits  <= 4'd10;
      ways_cfg    <= 4'd8;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_POLICY: policy      <= cfg_wdata[0];
        REG_OFFSET: offset_bits <= cfg_wdata[3:0];
        REG_INDEX:  index_bits  <= cfg_wdata[3:0];
        REG_WAYS:   ways_cfg    <= cfg_wdata[3:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_CLR;
      clr_addr <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if (wb_fire) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        ST_CLR: begin
          if (clr_addr == SET_W'(SETS - 1)) begin
            state <= ST_IDLE;
          end else begin
            clr_addr <= clr_addr + SET_W'(1);
          end
        end
        ST_IDLE: begin
          if (accept) begin
            state <= ST_MAP;
          end
        end
        ST_MAP: begin
          if (map_done) begin
            state <= ST_LOOK;
          end
        end
        ST_LOOK: begin
          state <= rnd_step ? ST_RND : ST_WB;
        end
        ST_RND: begin
          if (rnd_done) begin
            state <= ST_WB;
          end
        end
        ST_WB: begin
          if (out_free) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd <= s_tuser;
    end
    if (rd_en) begin
      set_sel <= map_set;
    end
    if (state == ST_LOOK) begin
      hit         <= hit_c;
      found_empty <= !hit_c && empty_c;
      rnd         <= rnd_step;
      if (hit_c) begin
        way <= hit_way_c;
      end else if (empty_c) begin
        way <= empty_way_c;
      end else begin
        way <= lru_way_c;
      end
    end
    if (wb_fire) begin
      out_hit    <= hit;
      out_way    <= 3'(way_fin);
      out_filled <= found_empty;
    end
  end

  sac_set_map #(
    .SETS(SETS)
  ) u_set_map (
    .clk        (clk),
    .rst        (rst),
    .start      (accept),
    .addr       (s_tdata),
    .offset_bits(offset_bits),
    .index_bits (index_bits),
    .done       (map_done),
    .set_idx    (map_set),
    .tag        (map_tag)
  );

  sac_tag_mem #(
    .DEPTH(SETS),
    .ROW_W(ROW_W)
  ) u_tag_mem (
    .clk    (clk),
    .rd_en  (rd_en),
    .rd_addr(map_set),
    .rd_data(rd_row),
    .wr_en  (wr_en),
    .wr_addr(wr_addr),
    .wr_data(wr_row)
  );

  sac_rand u_rand (
    .clk      (clk),
    .rst      (rst),
    .seed_load(cfg_we && (cfg_addr == REG_SEED)),
    .seed     (cfg_wdata),
    .step     (rnd_step),
    .ways     (ways_eff),
    .done     (rnd_done),
    .rem      (rnd_rem)
  );

  sac_stats u_stats (
    .clk  (clk),
    .rst  (rst),
    .upd  (upd),
    .stats(stats)
  );

endmodule

[tb/sv/tag_lookup_checker.sv]
// Checker that predicts every lookup of the cache tag directory and compares each result beat.
module tag_lookup_checker
  import sac_pkg::*;
#(
  parameter int SETS     = SETS_DEF,
  parameter int WAYS     = WAYS_DEF,
  parameter int AGE_BITS = AGE_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  input  logic                  s_tready,
  input  logic [ADDR_W-1:0]     s_tdata,   // addr
  input  logic                  s_tuser,   // cmd
  input  logic                  m_tvalid,
  input  logic                  m_tready,
  // hit, way_used[3], filled_empty, access, read, write, hit, miss, read miss,
  // write miss counts (32 each), zero pad
  input  logic [OUT_DATA_W-1:0] m_tdata,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_addr,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  output int                    errors,
  output int                    outstanding,
  output int                    hits_seen,
  output int                    evictions_seen
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [2:0] pad;
    stats_t     counts;
    logic       filled_empty;
    logic [2:0] way_used;
    logic       hit;
  } lookup_beat_t;

  localparam int ENTRIES = SETS * WAYS;

  logic                row_valid [ENTRIES];
  logic [TAG_W-1:0]    row_tag   [ENTRIES];
  logic [AGE_BITS-1:0] row_age   [ENTRIES];
  stats_t              totals;
  logic [31:0]         lfsr;
  logic                policy;
  logic [3:0]          offset_w;
  logic [3:0]          index_w;
  logic [3:0]          ways_reg;
  lookup_beat_t        expected_lookups [$];

  function automatic logic [CNT_W-1:0] sat_inc(logic [CNT_W-1:0] v);
    return (&v) ? v : v + 1'b1;
  endfunction

  function automatic void age_row(int unsigned base, int unsigned nways, int unsigned keep);
    for (int unsigned w = 0; w < nways; w++) begin
      if (!(&row_age[base + w])) row_age[base + w] = row_age[base + w] + 1'b1;
    end
    row_age[base + keep] = '0;
  endfunction

  function automatic lookup_beat_t predict_lookup(logic is_write, logic [ADDR_W-1:0] addr);
    lookup_beat_t     beat;
    logic [TAG_W-1:0] tag;
    logic [63:0]      set_no;
    int unsigned      nways;
    int unsigned      base;
    int unsigned      way;
    int unsigned      split;
    logic             found;
    logic             empty;
    beat  = '0;
    found = 1'b0;
    empty = 1'b0;
    way   = 0;
    nways = (ways_reg == 0) ? 1 : (ways_reg > WAYS) ? WAYS : ways_reg;
    split = offset_w + index_w;
    set_no = (addr >> offset_w) & ((64'd1 << index_w) - 64'd1);
    tag    = addr >> split;
    base   = (set_no % SETS) * WAYS;

    totals.accesses = sat_inc(totals.accesses);
    if (is_write == CMD_WRITE) totals.writes = sat_inc(totals.writes);
    else totals.reads = sat_inc(totals.reads);

    for (int unsigned w = 0; w < nways && !found; w++) begin
      if (row_valid[base + w] && row_tag[base + w] == tag) begin
        found = 1'b1;
        way   = w;
      end
    end

    if (found) begin
      totals.hits = sat_inc(totals.hits);
      age_row(base, nways, way);
      hits_seen++;
    end else begin
      totals.miss = sat_inc(totals.miss);
      if (is_write == CMD_WRITE) totals.write_miss = sat_inc(totals.write_miss);
      else totals.read_miss = sat_inc(totals.read_miss);
      for (int unsigned w = 0; w < nways && !empty; w++) begin
        if (!row_valid[base + w]) begin
          empty = 1'b1;
          way   = w;
        end
      end
      if (!empty) begin
        evictions_seen++;
        if (policy == POLICY_LRU) begin
          way = 0;
          for (int unsigned w = 1; w < nways; w++) begin
            if (row_age[base + w] > row_age[base + way]) way = w;
          end
        end else begin
          lfsr = lfsr[0] ? ((lfsr >> 1) ^ LFSR_TAPS) : (lfsr >> 1);
          way  = lfsr % nways;
        end
      end
      row_valid[base + way] = 1'b1;
      row_tag[base + way]   = tag;
      if (policy == POLICY_LRU) age_row(base, nways, way);
    end

    beat.hit          = found;
    beat.way_used     = way[2:0];
    beat.filled_empty = empty;
    beat.counts       = totals;
    return beat;
  endfunction

  task automatic check_field(string name, logic [CNT_W-1:0] want, logic [CNT_W-1:0] got);
    if (got !== want) begin
      errors++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin
    lookup_beat_t got;
    lookup_beat_t want;
    if (rst) begin
      for (int i = 0; i < ENTRIES; i++) begin
        row_valid[i] = 1'b0;
        row_tag[i]   = '0;
        row_age[i]   = '0;
      end
      totals   = '0;
      lfsr     = LFSR_RESET;
      policy   = POLICY_LRU;
      offset_w = 4'd6;
      index_w  = 4'd10;
      ways_reg = 4'd8;
      expected_lookups.delete();
      errors         = 0;
      hits_seen      = 0;
      evictions_seen = 0;
      outstanding <= 0;
    end else begin
      if (cfg_we) begin
        case (cfg_addr)
          REG_POLICY: policy = cfg_wdata[0];
          REG_OFFSET: offset_w = cfg_wdata[3:0];
          REG_INDEX:  index_w = cfg_wdata[3:0];
          REG_WAYS:   ways_reg = cfg_wdata[3:0];
          REG_SEED:   lfsr = (cfg_wdata == '0) ? LFSR_RESET : cfg_wdata;
          default: ;
        endcase
      end
      if (s_tvalid && s_tready) expected_lookups.push_back(predict_lookup(s_tuser, s_tdata));
      if (m_tvalid && m_tready) begin
        got = m_tdata;
        if (expected_lookups.size() == 0) begin
          errors++;
          $display("%0t: result beat with no access outstanding, expected none, actual %h",
                   $time, got);
        end else begin
          want = expected_lookups.pop_front();
          check_field("hit", want.hit, got.hit);
          check_field("way_used", want.way_used, got.way_used);
          check_field("filled_empty", want.filled_empty, got.filled_empty);
          check_field("access_count", want.counts.accesses, got.counts.accesses);
          check_field("read_count", want.counts.reads, got.counts.reads);
          check_field("write_count", want.counts.writes, got.counts.writes);
          check_field("hit_count", want.counts.hits, got.counts.hits);
          check_field("miss_count", want.counts.miss, got.counts.miss);
          check_field("read_miss_count", want.counts.read_miss, got.counts.read_miss);
          check_field("write_miss_count", want.counts.write_miss, got.counts.write_miss);
        end
      end
      outstanding <= expected_lookups.size();
    end
  end

endmodule

[tb/sv/set_assoc_cache_tag_lru_top_tb.sv]
// Testbench top: drives accesses and register writes into the tag directory, gives the verdict.
module set_assoc_cache_tag_lru_top_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import sac_pkg::*;

  localparam int   CLK_PERIOD        = 10;
  localparam int   RST_CYCLES        = 7;
  localparam int   WATCHDOG_LIMIT    = 5000;
  localparam int   RANDOM_SETTINGS   = 8;
  localparam int   ITEMS_PER_SETTING = 130;
  localparam int   TIE_SET           = 700;
  localparam int   TAIL_CYCLES       = 20;
  localparam logic CMD_READ          = ~CMD_WRITE;

  logic                  clk       = 1'b0;
  logic                  rst       = 1'b1;
  logic                  s_tvalid  = 1'b0;
  logic                  s_tready;
  logic [ADDR_W-1:0]     s_tdata   = '0;    // addr
  logic                  s_tuser   = 1'b0;  // cmd
  logic                  m_tvalid;
  logic                  m_tready  = 1'b1;
  // hit, way_used[3], filled_empty, seven 32-bit counts, zero pad
  logic [OUT_DATA_W-1:0] m_tdata;
  logic                  cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_addr  = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  int   errors;
  int   outstanding;
  int   hits_seen;
  int   evictions_seen;
  int   accesses_sent = 0;
  int   settings_used = 0;
  int   quiet_cycles  = 0;
  logic idle_on       = 1'b0;

  always #(CLK_PERIOD / 2) clk = ~clk;

  set_assoc_cache_tag_lru_top i_dut (.*);

  tag_lookup_checker i_checker (.*);

  task automatic send_access(logic cmd, logic [ADDR_W-1:0] addr);
    if (idle_on && $urandom_range(0, 5) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= addr;
    s_tuser  <= cmd;
    do @(posedge clk); while (!s_tready);
    accesses_sent++;
  endtask

  task automatic wait_drained();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic apply_setting(logic pol, int unsigned off, int unsigned idx,
                               int unsigned ways, logic [31:0] seed);
    wait_drained();
    write_reg(REG_POLICY, CFG_DATA_W'(pol));
    write_reg(REG_OFFSET, off);
    write_reg(REG_INDEX, idx);
    write_reg(REG_WAYS, ways);
    write_reg(REG_SEED, seed);
    settings_used++;
  endtask

  function automatic logic [ADDR_W-1:0] make_addr(logic [63:0] tag, int unsigned set_no,
                                                  int unsigned off, int unsigned idx);
    logic [ADDR_W-1:0] low;
    low = {$urandom, $urandom};
    return (tag << (off + idx)) | ((64'(set_no) & ((64'd1 << idx) - 64'd1)) << off)
           | (low & ((64'd1 << off) - 64'd1));
  endfunction

  initial begin
    int hold;
    hold = 0;
    forever begin
      @(posedge clk);
      if (hold > 0) begin
        hold--;
        if (hold == 0) m_tready <= 1'b1;
      end else if (idle_on && $urandom_range(0, 9) == 0) begin
        hold = $urandom_range(1, 9);
        m_tready <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin
    logic          pol;
    int unsigned   off;
    int unsigned   idx;
    int unsigned   nways;
    int unsigned   eff;
    logic [31:0]   seed;
    logic [63:0]   tag;
    repeat (RST_CYCLES) @(posedge clk);
    rst <= 1'b0;

    send_access(CMD_READ, '0);
    send_access(CMD_WRITE, '0);
    send_access(CMD_READ, '1);
    send_access(CMD_WRITE, {1'b1, 63'd0});
    for (int t = 1; t <= 6; t++) send_access(CMD_READ, 64'(t) << 16);

    // Random replacement from a zero seed, and writes to indexes past the last register.
    apply_setting(POLICY_RAND, 0, 2, 3, 32'd0);
    for (int r = REG_SEED + 1; r < 2 ** CFG_IDX_W; r++) write_reg(CFG_IDX_W'(r), '1);
    for (int t = 0; t < 5; t++) send_access(t[0], (64'(t) << 2) | 64'd1);

    // A way count of zero and a set index that wraps beyond the built sets.
    apply_setting(POLICY_LRU, 15, 15, 0, 32'd1);
    send_access(CMD_READ, 64'd20000 << 15);
    send_access(CMD_WRITE, (64'd1 << 30) | (64'd20000 << 15));
    send_access(CMD_READ, 64'd18976 << 15);

    // A way count above the built ways, with a single set.
    apply_setting(POLICY_LRU, 12, 0, 15, 32'hFFFF_FFFF);
    for (int t = 0; t < 9; t++) send_access(CMD_READ, 64'(t + 100) << 12);

    idle_on = 1'b1;
    for (int k = 0; k < RANDOM_SETTINGS; k++) begin
      if (k == RANDOM_SETTINGS - 1) begin
        // Random fills leave the ages alone, so a following LRU eviction meets tied ages.
        idle_on = 1'b0;
        apply_setting(POLICY_RAND, 6, 10, 3, 32'd1);
        for (int t = 0; t < 3; t++)
          send_access(CMD_WRITE, make_addr(64'h5A5A_0000 + t, TIE_SET, 6, 10));
        apply_setting(POLICY_LRU, 6, 10, 3, 32'd1);
        for (int t = 3; t < 5; t++)
          send_access(CMD_READ, make_addr(64'h5A5A_0000 + t, TIE_SET, 6, 10));
      end
      case (k)
        0: begin
          pol = POLICY_LRU; off = 0; idx = 0; nways = 8; seed = 32'd1;
        end
        1: begin
          pol = POLICY_RAND; off = 12; idx = 10; nways = 1; seed = 32'hFFFF_FFFF;
        end
        2: begin
          pol = POLICY_RAND; off = 15; idx = 15; nways = 15; seed = $urandom;
        end
        default: begin
          pol   = 1'($urandom_range(0, 1));
          off   = $urandom_range(0, 15);
          idx   = $urandom_range(0, 3);
          nways = $urandom_range(0, 15);
          seed  = ($urandom_range(0, 3) == 0) ? 32'd0 : $urandom;
        end
      endcase
      apply_setting(pol, off, idx, nways, seed);
      eff = (nways == 0) ? 1 : (nways > WAYS_DEF) ? WAYS_DEF : nways;
      for (int n = 0; n < ITEMS_PER_SETTING; n++) begin
        if ($urandom_range(0, 99) == 0) wait_drained();
        if ($urandom_range(0, 6) == 0) begin
          send_access(1'($urandom_range(0, 1)), {$urandom, $urandom});
        end else begin
          tag = 64'($urandom_range(0, 2 * eff + 1));
          send_access(1'($urandom_range(0, 1)),
                      make_addr(tag, $urandom_range(0, 3), off, idx));
        end
      end
    end

    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    $display("Summary: %0d accesses over %0d register settings;", accesses_sent,
             settings_used);
    $display("Summary: %0d hits and %0d full-set evictions checked, both policies, %s",
             hits_seen, evictions_seen, "odd way counts, set wrap, zero seed and tied ages.");
    if (errors == 0 && outstanding == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

[filelist.f]
src/sac_pkg.sv
src/sac_tag_mem.sv
src/sac_set_map.sv
src/sac_rand.sv
src/sac_stats.sv
src/set_assoc_cache_tag_lru_top.sv
tb/sv/tag_lookup_checker.sv
tb/sv/set_assoc_cache_tag_lru_top_tb.sv
